>>> rtl/triangle_unit_normal_top_assert.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TUN_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tun assertion failed");
`define TUN_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tun assertion failed");
`else
`define TUN_ASSERT_IMP(lbl, pre, post)
`define TUN_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> rtl/tun_pkg.sv
package tun_pkg;

	localparam int CoordW  = 16;               // vertex coordinate
	localparam int DiffW   = CoordW + 1;       // edge component
	localparam int ProdW   = 2 * DiffW;        // edge product
	localparam int CrossW  = ProdW + 1;        // cross component, signed
	localparam int MagW    = CrossW - 1;       // cross magnitude
	localparam int SclW    = 31;               // magnitude after scaling
	localparam int ShiftMax = MagW - SclW;
	localparam int ShiftW  = $clog2(ShiftMax + 1);
	localparam int SqW     = 2 * SclW;
	localparam int SumW    = SqW + 2;
	localparam int RootW   = SumW / 2;
	localparam int FracW   = 14;               // normal fraction bits
	localparam int OutW    = FracW + 2;
	localparam int QuotW   = FracW + 1;
	localparam int NumW    = SclW + FracW + 1;
	localparam int DremW   = NumW + 1;

	typedef struct packed {
		logic [2:0][SclW-1:0] mag;
		logic [2:0]           neg;
		logic                 degen;
	} side_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} flag_t;

endpackage

>>> rtl/triangle_unit_normal_top.sv
// Unit face normal of a triangle. Each transaction on the tri channel carries three
// vertices in signed Q8.8; the nrm channel returns the unit normal of (v1-v0) x (v2-v0)
// in signed Q1.14, rounded to nearest, with degenerate set and a zero normal when the
// cross product is zero. The pipeline takes one triangle per clock. From
// acceptance to a valid result it passes the edge, product, cross, magnitude,
// scaling, square and sum stages, the bit-per-stage square root, a stage that forms
// the rounded dividend, the bit-per-stage dividers (one per component) and the
// output register. All stages advance together; when the result is not taken, the
// whole pipeline holds and tri_ready drops.
module triangle_unit_normal_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tri_valid,
	output logic                               tri_ready,
	input  logic signed [tun_pkg::CoordW-1:0]  vert0_x,
	input  logic signed [tun_pkg::CoordW-1:0]  vert0_y,
	input  logic signed [tun_pkg::CoordW-1:0]  vert0_z,
	input  logic signed [tun_pkg::CoordW-1:0]  vert1_x,
	input  logic signed [tun_pkg::CoordW-1:0]  vert1_y,
	input  logic signed [tun_pkg::CoordW-1:0]  vert1_z,
	input  logic signed [tun_pkg::CoordW-1:0]  vert2_x,
	input  logic signed [tun_pkg::CoordW-1:0]  vert2_y,
	input  logic signed [tun_pkg::CoordW-1:0]  vert2_z,
	output logic                               nrm_valid,
	input  logic                               nrm_ready,
	output logic signed [tun_pkg::OutW-1:0]    normal_x,
	output logic signed [tun_pkg::OutW-1:0]    normal_y,
	output logic signed [tun_pkg::OutW-1:0]    normal_z,
	output logic                               degenerate
);
	import tun_pkg::*;

	localparam int NStg = 7 + RootW + 1 + QuotW + 1;

	logic            en;
	logic [NStg:1]   v_s;

	assign en        = !v_s[NStg] || nrm_ready;
	assign tri_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NStg-1:1], tri_valid};
		end
	end

	// s1: edges
	logic signed [DiffW-1:0] a_s1 [3];
	logic signed [DiffW-1:0] b_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= DiffW'(vert1_x) - DiffW'(vert0_x);
			a_s1[1] <= DiffW'(vert1_y) - DiffW'(vert0_y);
			a_s1[2] <= DiffW'(vert1_z) - DiffW'(vert0_z);
			b_s1[0] <= DiffW'(vert2_x) - DiffW'(vert0_x);
			b_s1[1] <= DiffW'(vert2_y) - DiffW'(vert0_y);
			b_s1[2] <= DiffW'(vert2_z) - DiffW'(vert0_z);
		end
	end

	// s2: six products
	logic signed [ProdW-1:0] p_s2 [6];
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= a_s1[1] * b_s1[2];
			p_s2[1] <= a_s1[2] * b_s1[1];
			p_s2[2] <= a_s1[2] * b_s1[0];
			p_s2[3] <= a_s1[0] * b_s1[2];
			p_s2[4] <= a_s1[0] * b_s1[1];
			p_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	// s3: cross product
	logic signed [CrossW-1:0] c_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= CrossW'(p_s2[2*i]) - CrossW'(p_s2[2*i+1]);
			end
		end
	end

	// s4: sign and magnitude
	logic [MagW-1:0] mag_s4 [3];
	logic [2:0]      neg_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][CrossW-1];
				mag_s4[i] <= c_s3[i][CrossW-1] ? MagW'(-c_s3[i]) : MagW'(c_s3[i]);
			end
		end
	end

	// s5: scale so the largest magnitude fits SclW bits
	logic [MagW-1:0]   mag_or;
	logic [ShiftW-1:0] shamt;
	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		shamt  = '0;
		for (int i = 1; i <= ShiftMax; i++) begin
			if (mag_or[SclW-1+i]) begin
				shamt = ShiftW'(i);
			end
		end
	end

	logic [SclW-1:0] mag_s5 [3];
	logic [2:0]      neg_s5;
	logic            degen_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s5[i] <= SclW'(mag_s4[i] >> shamt);
			end
			neg_s5   <= neg_s4;
			degen_s5 <= (mag_or == '0);
		end
	end

	// s6: squares
	logic [SqW-1:0] sq_s6 [3];
	side_t          side_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i]       <= SqW'(mag_s5[i]) * SqW'(mag_s5[i]);
				side_s6.mag[i] <= mag_s5[i];
			end
			side_s6.neg   <= neg_s5;
			side_s6.degen <= degen_s5;
		end
	end

	// s7: sum of squares
	logic [SumW-1:0] sum_s7;
	side_t           side_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SumW'(sq_s6[0]) + SumW'(sq_s6[1]) + SumW'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// square root, one result bit per stage
	logic [SumW-1:0]  rem_sr  [RootW];
	logic [RootW-1:0] root_sr [RootW];
	side_t            side_sr [RootW];

	for (genvar j = 0; j < RootW; j++) begin : g_sqrt
		localparam int Bit = RootW - 1 - j;
		logic [SumW-1:0]  rem_in;
		logic [RootW-1:0] root_in;
		side_t            side_in;
		logic [SumW:0]    trial;
		if (j == 0) begin : g_first
			assign rem_in  = sum_s7;
			assign root_in = '0;
			assign side_in = side_s7;
		end else begin : g_next
			assign rem_in  = rem_sr[j-1];
			assign root_in = root_sr[j-1];
			assign side_in = side_sr[j-1];
		end
		assign trial = ((SumW+1)'(root_in) << (Bit + 1)) | ((SumW+1)'(1) << (2 * Bit));
		always_ff @(posedge clk) begin
			if (en) begin
				side_sr[j] <= side_in;
				if ({1'b0, rem_in} >= trial) begin
					rem_sr[j]  <= SumW'({1'b0, rem_in} - trial);
					root_sr[j] <= root_in | (RootW'(1) << Bit);
				end else begin
					rem_sr[j]  <= rem_in;
					root_sr[j] <= root_in;
				end
			end
		end
	end

	// rounded dividend
	logic [RootW-1:0] len;
	logic [NumW-1:0]  num_sn [3];
	logic [RootW-1:0] len_sn;
	flag_t            flag_sn;
	assign len = (root_sr[RootW-1] == '0) ? RootW'(1) : root_sr[RootW-1];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_sn[i] <= (NumW'(side_sr[RootW-1].mag[i]) << FracW) + NumW'(len >> 1);
			end
			len_sn        <= len;
			flag_sn.neg   <= side_sr[RootW-1].neg;
			flag_sn.degen <= side_sr[RootW-1].degen;
		end
	end

	// dividers, one quotient bit per stage
	logic [DremW-1:0] drem_sd [QuotW][3];
	logic [QuotW-1:0] quo_sd  [QuotW][3];
	logic [RootW-1:0] len_sd  [QuotW];
	flag_t            flag_sd [QuotW];

	for (genvar j = 0; j < QuotW; j++) begin : g_div
		localparam int Bit = QuotW - 1 - j;
		logic [DremW-1:0] rem_in [3];
		logic [QuotW-1:0] quo_in [3];
		logic [RootW-1:0] len_in;
		flag_t            flag_in;
		logic [DremW-1:0] dsub;
		if (j == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = DremW'(num_sn[i]);
					quo_in[i] = '0;
				end
			end
			assign len_in  = len_sn;
			assign flag_in = flag_sn;
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = drem_sd[j-1][i];
					quo_in[i] = quo_sd[j-1][i];
				end
			end
			assign len_in  = len_sd[j-1];
			assign flag_in = flag_sd[j-1];
		end
		assign dsub = DremW'(len_in) << Bit;
		always_ff @(posedge clk) begin
			if (en) begin
				len_sd[j]  <= len_in;
				flag_sd[j] <= flag_in;
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= dsub) begin
						drem_sd[j][i] <= rem_in[i] - dsub;
						quo_sd[j][i]  <= quo_in[i] | (QuotW'(1) << Bit);
					end else begin
						drem_sd[j][i] <= rem_in[i];
						quo_sd[j][i]  <= quo_in[i];
					end
				end
			end
		end
	end

	// output register: clamp, sign, degenerate override
	localparam logic [QuotW-1:0] One = QuotW'(1) << FracW;
	logic [OutW-1:0] nrm_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [QuotW-1:0] q;
			q = (quo_sd[QuotW-1][i] > One) ? One : quo_sd[QuotW-1][i];
			if (flag_sd[QuotW-1].degen) begin
				nrm_c[i] = '0;
			end else if (flag_sd[QuotW-1].neg[i]) begin
				nrm_c[i] = -OutW'(q);
			end else begin
				nrm_c[i] = OutW'(q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			normal_x   <= nrm_c[0];
			normal_y   <= nrm_c[1];
			normal_z   <= nrm_c[2];
			degenerate <= flag_sd[QuotW-1].degen;
		end
	end

	assign nrm_valid = v_s[NStg];

`include "triangle_unit_normal_top_assert.svh"

	`TUN_ASSERT_IMP(a_degen_zero, nrm_valid && degenerate,
		normal_x == '0 && normal_y == '0 && normal_z == '0)
	`TUN_ASSERT_IMP(a_root_nonzero, v_s[7 + RootW] && !side_sr[RootW-1].degen,
		root_sr[RootW-1] != '0)
	`TUN_ASSERT_IMP(a_x_range, nrm_valid,
		$signed(normal_x) <= $signed(OutW'(One)) && $signed(normal_x) >= -$signed(OutW'(One)))
	`TUN_ASSERT_IMP(a_nonzero_normal, nrm_valid && !degenerate,
		normal_x != '0 || normal_y != '0 || normal_z != '0)
	`TUN_ASSERT_IMP(a_ready_stall, !tri_ready, nrm_valid && !nrm_ready)

endmodule
